@@ hw/rtl/rlt_pkg.sv @@
`timescale 1ns / 1ps
package rlt_pkg;

  localparam int ADDR_W = 15;
  localparam int WORD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int STEP_W = 24;
  localparam int PROD_W = ANGLE_W + STEP_W;
  localparam int FRAC_LSB = 6;
  localparam int INT_LSB = 22;
  localparam int NEIGHBORS = 8;

  localparam logic signed [17:0] NIGHT_LIMIT = 18'sd5632;
  localparam logic signed [17:0] HALF_TURN = 18'sd11520;
  localparam logic signed [17:0] FULL_TURN = 18'sd23040;

  // percent to reflectance: (r * 32 + 50) / 100 by reciprocal
  localparam int SCALE_N_W = 22;
  localparam int RECIP_SHIFT = 28;
  localparam logic [21:0] RECIP_100 = 22'd2684354;
  localparam logic [21:0] PCT_ROUND = 22'd50;
  localparam logic [21:0] PCT_DIV = 22'd100;

  typedef enum logic [2:0] {
    CFG_SOLAR_BOUNDS   = 3'd0,
    CFG_VIEW_BOUNDS    = 3'd1,
    CFG_AZIMUTH_BOUNDS = 3'd2,
    CFG_SOLAR_STEP     = 3'd3,
    CFG_VIEW_STEP      = 3'd4,
    CFG_AZIMUTH_STEP   = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CORRECTED = 3'd0,
    ST_CLAMPED   = 3'd1,
    ST_NIGHT     = 3'd2,
    ST_NO_DATA   = 3'd3,
    ST_WRITTEN   = 3'd4
  } status_t;

  localparam logic OP_WRITE = 1'b0;

  // per-beat sideband that rides along the pipeline
  typedef struct packed {
    logic                interp;
    logic                is_write;
    status_t             status;
    logic [WORD_W-1:0]   refl;
    logic [ADDR_W-1:0]   widx;
    logic [WORD_W-1:0]   wdata;
    logic [15:0]         fs;
    logic [15:0]         fv;
    logic [15:0]         fa;
  } rlt_tag_t;

endpackage

@@ hw/rtl/rayleigh_lut_trilinear_correction_core.sv @@
`timescale 1ns / 1ps
// Rayleigh correction by trilinear table lookup.
// Input channel (in_valid/in_ready): op 0 writes entry_value to table word
// entry_index; op 1 corrects one pixel from its three angles and reflectance.
// Output channel (out_valid/out_ready): one beat per input beat, in order,
// carrying corrected and status.
// Configuration: cfg_we with cfg_index/cfg_data writes bounds and reciprocal
// steps; write only while the pipeline is empty.
// Stages from input accept to output valid: prep, multiply, index, address,
// table read, three blend levels, scale, final subtract.
// Throughput: one beat per cycle while out_ready is high; each of the eight
// corners reads its own table copy so all neighbours arrive in the same cycle.
// Stall: each stage holds while the one after it is full and stalled, so
// bubbles close up and in_ready drops only when every stage holds a beat and
// out_ready is low.
// Reset: clears valid bits and configuration (bounds 0, steps 1.0); table
// contents are undefined until written.
module rayleigh_lut_trilinear_correction_core import rlt_pkg::*; #(
  parameter int SOLAR_POINTS = 32,
  parameter int VIEW_POINTS = 32,
  parameter int AZIMUTH_POINTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [ADDR_W-1:0]  entry_index,
  input  logic [WORD_W-1:0]  entry_value,
  input  logic signed [15:0] solar_zenith,
  input  logic signed [15:0] view_zenith,
  input  logic signed [15:0] rel_azimuth,
  input  logic [WORD_W-1:0]  reflectance,
  input  logic               reflectance_missing,
  input  logic               solar_missing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  corrected,
  output logic [2:0]         status
);

  localparam int NS = 10;

  logic [31:0]       solar_bounds, view_bounds, azimuth_bounds;
  logic [STEP_W-1:0] solar_inv_step, view_inv_step, azimuth_inv_step;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  rlt_tag_t      tag [NS];
  rlt_tag_t      tag_d;

  logic [15:0]       d_s, d_v, d_a;
  logic [15:0]       fs, fv, fa;
  logic [ADDR_W-1:0] addr [NEIGHBORS];
  logic [WORD_W-1:0] corner [NEIGHBORS];
  logic [WORD_W-1:0] c_az [4];
  logic [WORD_W-1:0] c_vw [2];
  logic [WORD_W-1:0] r_pct;
  logic [SCALE_N_W-1:0] num;
  logic [15:0]          q_est;
  logic [SCALE_N_W+SCALE_N_W-1:0] q_prod;
  logic [SCALE_N_W-1:0] rem;
  logic [15:0]          rc;
  logic [WORD_W-1:0]    corrected_next;
  status_t              status_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      solar_bounds <= '0;
      view_bounds <= '0;
      azimuth_bounds <= '0;
      solar_inv_step <= STEP_W'(65536);
      view_inv_step <= STEP_W'(65536);
      azimuth_inv_step <= STEP_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOLAR_BOUNDS:   solar_bounds <= cfg_data;
        CFG_VIEW_BOUNDS:    view_bounds <= cfg_data;
        CFG_AZIMUTH_BOUNDS: azimuth_bounds <= cfg_data;
        CFG_SOLAR_STEP:     solar_inv_step <= cfg_data[STEP_W-1:0];
        CFG_VIEW_STEP:      view_inv_step <= cfg_data[STEP_W-1:0];
        CFG_AZIMUTH_STEP:   azimuth_inv_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one loads
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // sideband pipeline; fractions join it after the index stage
  always_ff @(posedge clk) begin
    if (en[0]) tag[0] <= tag_d;
    for (int k = 1; k < NS; k++) begin
      if (en[k] && k != 3) tag[k] <= tag[k-1];
    end
    if (en[3]) begin
      tag[3] <= tag[2];
      tag[3].fs <= fs;
      tag[3].fv <= fv;
      tag[3].fa <= fa;
    end
  end

  rlt_angle_prep u_prep (
    .clk, .en(en[0]), .op, .entry_index, .entry_value,
    .solar_zenith, .view_zenith, .rel_azimuth, .reflectance,
    .reflectance_missing, .solar_missing,
    .solar_bounds, .view_bounds, .azimuth_bounds,
    .tag_d, .d_s, .d_v, .d_a
  );

  rlt_grid #(
    .SOLAR_POINTS(SOLAR_POINTS), .VIEW_POINTS(VIEW_POINTS),
    .AZIMUTH_POINTS(AZIMUTH_POINTS)
  ) u_grid (
    .clk, .stage_en(en[3:1]), .d_s, .d_v, .d_a,
    .inv_s(solar_inv_step), .inv_v(view_inv_step), .inv_a(azimuth_inv_step),
    .fs, .fv, .fa, .addr
  );

  rlt_lut_banks u_lut (
    .clk, .en(en[4]), .we(vld[3] && tag[3].is_write),
    .waddr(tag[3].widx), .wdata(tag[3].wdata),
    .raddr(addr), .rdata(corner)
  );

  // blend along azimuth, then view, then solar
  for (genvar i = 0; i < 4; i++) begin : g_az
    rlt_blend u_b (.clk, .en(en[5]), .a(corner[2*i]), .b(corner[2*i+1]),
                   .f(tag[4].fa), .q(c_az[i]));
  end
  for (genvar i = 0; i < 2; i++) begin : g_vw
    rlt_blend u_b (.clk, .en(en[6]), .a(c_az[2*i]), .b(c_az[2*i+1]),
                   .f(tag[5].fv), .q(c_vw[i]));
  end
  rlt_blend u_sol (.clk, .en(en[7]), .a(c_vw[0]), .b(c_vw[1]),
                   .f(tag[6].fs), .q(r_pct));

  // percent to reflectance: quotient estimate by reciprocal
  assign q_prod = (SCALE_N_W + SCALE_N_W)'({r_pct, 5'b0} + PCT_ROUND) * 44'(RECIP_100);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      num <= SCALE_N_W'({r_pct, 5'b0}) + PCT_ROUND;
      q_est <= q_prod[RECIP_SHIFT +: 16];
    end
  end

  // quotient correction and subtraction
  always_comb begin
    rem = num - SCALE_N_W'(q_est) * PCT_DIV;
    rc = (rem >= PCT_DIV) ? q_est + 16'd1 : q_est;
    corrected_next = tag[8].refl;
    status_next = tag[8].status;
    if (tag[8].interp) begin
      if (rc > tag[8].refl) begin
        corrected_next = '0;
        status_next = ST_CLAMPED;
      end else begin
        corrected_next = tag[8].refl - rc;
        status_next = ST_CORRECTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      corrected <= corrected_next;
      status <= status_next;
    end
  end

  assign out_valid = vld[NS-1];

`ifndef NO_ASSERTIONS
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the pipeline can advance");
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_WRITTEN || status == ST_CLAMPED || status == ST_NIGHT)
      |-> corrected == '0)
    else $error("nonzero result on a zero-result status");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
  a_write_tag: assert property (@(posedge clk) disable iff (rst)
    vld[3] && tag[3].is_write |-> !tag[3].interp)
    else $error("table write marked for interpolation");
`endif

endmodule

@@ hw/rtl/rlt_angle_prep.sv @@
`timescale 1ns / 1ps
module rlt_angle_prep import rlt_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic                op,
  input  logic [ADDR_W-1:0]   entry_index,
  input  logic [WORD_W-1:0]   entry_value,
  input  logic signed [15:0]  solar_zenith,
  input  logic signed [15:0]  view_zenith,
  input  logic signed [15:0]  rel_azimuth,
  input  logic [WORD_W-1:0]   reflectance,
  input  logic                reflectance_missing,
  input  logic                solar_missing,
  input  logic [31:0]         solar_bounds,
  input  logic [31:0]         view_bounds,
  input  logic [31:0]         azimuth_bounds,
  output rlt_tag_t            tag_d,
  output logic [15:0]         d_s,
  output logic [15:0]         d_v,
  output logic [15:0]         d_a
);

  // offset from the lower bound, saturated at zero
  function automatic logic [15:0] offset16(logic signed [17:0] x, logic signed [15:0] lo);
    logic signed [18:0] d;
    d = 19'(x) - 19'(lo);
    if (d < 0) return 16'd0;
    return d[15:0];
  endfunction

  logic signed [17:0] sz, vz, az_abs, az_fold, az_hi, az_c;
  logic signed [17:0] sz_c1, sz_c, vz_c1, vz_c;
  logic signed [15:0] s_lo, s_hi, v_lo, v_hi, a_lo, a_hi;
  logic               night;

  assign s_lo = solar_bounds[15:0];
  assign s_hi = solar_bounds[31:16];
  assign v_lo = view_bounds[15:0];
  assign v_hi = view_bounds[31:16];
  assign a_lo = azimuth_bounds[15:0];
  assign a_hi = azimuth_bounds[31:16];

  // zenith clamps: lower first, then upper
  always_comb begin
    sz = 18'(solar_zenith);
    vz = 18'(view_zenith);
    sz_c1 = (sz < 18'(s_lo)) ? 18'(s_lo) : sz;
    sz_c  = (sz_c1 >= 18'(s_hi)) ? 18'(s_hi) : sz_c1;
    vz_c1 = (vz < 18'(v_lo)) ? 18'(v_lo) : vz;
    vz_c  = (vz_c1 >= 18'(v_hi)) ? 18'(v_hi) : vz_c1;
  end

  // azimuth fold into a half turn, then upper and lower clamps
  always_comb begin
    az_abs  = (rel_azimuth < 0) ? -18'(rel_azimuth) : 18'(rel_azimuth);
    az_fold = (az_abs > HALF_TURN) ? (FULL_TURN - az_abs) : az_abs;
    az_hi   = (az_fold > 18'(a_hi)) ? 18'(a_hi) : az_fold;
    az_c    = (az_hi < 18'(a_lo)) ? 18'(a_lo) : az_hi;
  end

  // classify the beat
  assign night = solar_missing || (18'(solar_zenith) > NIGHT_LIMIT) || (solar_zenith < 0);

  always_comb begin
    tag_d = '0;
    tag_d.widx = entry_index;
    tag_d.wdata = entry_value;
    priority if (op == OP_WRITE) begin
      tag_d.is_write = 1'b1;
      tag_d.status = ST_WRITTEN;
    end else if (reflectance_missing) begin
      tag_d.status = ST_NO_DATA;
      tag_d.refl = reflectance;
    end else if (night) begin
      tag_d.status = ST_NIGHT;
    end else begin
      tag_d.interp = 1'b1;
      tag_d.status = ST_CORRECTED;
      tag_d.refl = reflectance;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s <= offset16(sz_c, s_lo);
      d_v <= offset16(vz_c, v_lo);
      d_a <= offset16(az_c, a_lo);
    end
  end

endmodule

@@ hw/rtl/rlt_grid.sv @@
`timescale 1ns / 1ps
module rlt_grid import rlt_pkg::*; #(
  parameter int SOLAR_POINTS = 32,
  parameter int VIEW_POINTS = 32,
  parameter int AZIMUTH_POINTS = 32
) (
  input  logic              clk,
  input  logic [2:0]        stage_en,
  input  logic [15:0]       d_s,
  input  logic [15:0]       d_v,
  input  logic [15:0]       d_a,
  input  logic [STEP_W-1:0] inv_s,
  input  logic [STEP_W-1:0] inv_v,
  input  logic [STEP_W-1:0] inv_a,
  output logic [15:0]       fs,
  output logic [15:0]       fv,
  output logic [15:0]       fa,
  output logic [ADDR_W-1:0] addr [NEIGHBORS]
);

  localparam int SW = $clog2(SOLAR_POINTS);
  localparam int VW = $clog2(VIEW_POINTS);
  localparam int AW = $clog2(AZIMUTH_POINTS);
  localparam int IP_W = PROD_W - INT_LSB;
  localparam int ROW = VIEW_POINTS * AZIMUTH_POINTS;

  localparam logic [IP_W-1:0] S_LAST = IP_W'(SOLAR_POINTS - 1);
  localparam logic [IP_W-1:0] V_LAST = IP_W'(VIEW_POINTS - 1);
  localparam logic [IP_W-1:0] A_LAST = IP_W'(AZIMUTH_POINTS - 1);

  logic [PROD_W-1:0] p_s, p_v, p_a;
  logic [SW-1:0] s0, s1;
  logic [VW-1:0] v0, v1;
  logic [AW-1:0] a0, a1;

  // angle offset times reciprocal step
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      p_s <= PROD_W'(d_s) * PROD_W'(inv_s);
      p_v <= PROD_W'(d_v) * PROD_W'(inv_v);
      p_a <= PROD_W'(d_a) * PROD_W'(inv_a);
    end
  end

  // grid index and fraction, held at the last point
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      if (p_s[PROD_W-1:INT_LSB] >= S_LAST) begin
        s0 <= SW'(SOLAR_POINTS - 1);
        s1 <= SW'(SOLAR_POINTS - 1);
        fs <= '0;
      end else begin
        s0 <= p_s[INT_LSB +: SW];
        s1 <= p_s[INT_LSB +: SW] + SW'(1);
        fs <= p_s[FRAC_LSB +: 16];
      end
      if (p_v[PROD_W-1:INT_LSB] >= V_LAST) begin
        v0 <= VW'(VIEW_POINTS - 1);
        v1 <= VW'(VIEW_POINTS - 1);
        fv <= '0;
      end else begin
        v0 <= p_v[INT_LSB +: VW];
        v1 <= p_v[INT_LSB +: VW] + VW'(1);
        fv <= p_v[FRAC_LSB +: 16];
      end
      if (p_a[PROD_W-1:INT_LSB] >= A_LAST) begin
        a0 <= AW'(AZIMUTH_POINTS - 1);
        a1 <= AW'(AZIMUTH_POINTS - 1);
        fa <= '0;
      end else begin
        a0 <= p_a[INT_LSB +: AW];
        a1 <= p_a[INT_LSB +: AW] + AW'(1);
        fa <= p_a[FRAC_LSB +: 16];
      end
    end
  end

  // flat addresses of the eight corners, wrapped to the store
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      for (int k = 0; k < NEIGHBORS; k++) begin
        addr[k] <= ADDR_W'(32'(k[2] ? s1 : s0) * ROW
                         + 32'(k[1] ? v1 : v0) * AZIMUTH_POINTS
                         + 32'(k[0] ? a1 : a0));
      end
    end
  end

endmodule

@@ hw/rtl/rlt_lut_banks.sv @@
`timescale 1ns / 1ps
module rlt_lut_banks import rlt_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr [NEIGHBORS],
  output logic [WORD_W-1:0] rdata [NEIGHBORS]
);

  localparam int DEPTH = 1 << ADDR_W;

  // one full copy per corner so each corner has its own read port
  for (genvar k = 0; k < NEIGHBORS; k++) begin : g_bank
    logic [WORD_W-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (en) begin
        if (we) mem[waddr] <= wdata;
        rdata[k] <= mem[raddr[k]];
      end
    end
  end

endmodule

@@ hw/rtl/rlt_blend.sv @@
`timescale 1ns / 1ps
module rlt_blend import rlt_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [15:0]       f,
  output logic [WORD_W-1:0] q
);

  // a + round((b - a) * f / 65536), same as a*(1-f) + b*f rounded
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [33:0] rnd;
  logic signed [17:0] sum;

  assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod = 34'(diff) * 34'($signed({1'b0, f}));
  assign rnd = prod + 34'sd32768;
  assign sum = $signed({2'b00, a}) + rnd[33:16];

  always_ff @(posedge clk) begin
    if (en) q <= sum[WORD_W-1:0];
  end

endmodule
